// ===== hdl/imutf_pkg.sv =====
// ----------------------------------------------------------------------------
// imutf_pkg: shared types and constants of the IMU tilt filter
// Item and result structs, register indexes, engine states and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package imutf_pkg;

  localparam int CordicIterationsDefault = 16;
  localparam int AtanLen                 = 24;
  localparam int QueueDepthDefault       = 2;

  localparam logic [19:0] GyroScaleReset  = 20'd128070;
  localparam logic [16:0] GyroWeightReset = 17'd62915;

  // One input beat
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic        [31:0] timestamp_ms;
  } in_item_t;

  // One result beat
  typedef struct packed {
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
    logic        [31:0] elapsed_ms;
  } out_item_t;

  // Sample as queued between front and back: raw axes plus elapsed time
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic        [31:0] dt;
  } work_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic signed [23:0] offset_roll;
    logic signed [23:0] offset_pitch;
    logic signed [24:0] offset_x;
    logic signed [24:0] offset_y;
    logic signed [24:0] offset_z;
    logic        [19:0] scale;
    logic        [16:0] weight;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_ACCEL_OFFSET_ROLL  = 3'd0,
    REG_ACCEL_OFFSET_PITCH = 3'd1,
    REG_GYRO_OFFSET_X      = 3'd2,
    REG_GYRO_OFFSET_Y      = 3'd3,
    REG_GYRO_OFFSET_Z      = 3'd4,
    REG_GYRO_SCALE         = 3'd5,
    REG_GYRO_WEIGHT        = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_PREP_MUL,
    BK_PREP_ADD,
    BK_PREP_DT,
    BK_PREP_DIV,
    BK_RUN,
    BK_ANGLE,
    BK_BLEND,
    BK_OUT
  } back_state_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [22:0] atan_entry(input logic [4:0] i);
    logic [22:0] v;
    unique case (i)
      5'd0:    v = 23'd2949120;
      5'd1:    v = 23'd1740967;
      5'd2:    v = 23'd919879;
      5'd3:    v = 23'd466945;
      5'd4:    v = 23'd234379;
      5'd5:    v = 23'd117304;
      5'd6:    v = 23'd58666;
      5'd7:    v = 23'd29335;
      5'd8:    v = 23'd14668;
      5'd9:    v = 23'd7334;
      5'd10:   v = 23'd3667;
      5'd11:   v = 23'd1833;
      5'd12:   v = 23'd917;
      5'd13:   v = 23'd458;
      5'd14:   v = 23'd229;
      5'd15:   v = 23'd115;
      5'd16:   v = 23'd57;
      5'd17:   v = 23'd29;
      5'd18:   v = 23'd14;
      5'd19:   v = 23'd7;
      5'd20:   v = 23'd4;
      5'd21:   v = 23'd2;
      5'd22:   v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/imu_complementary_tilt_filter_core.sv =====
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_core: roll/pitch/yaw complementary filter
//
//   channel  | handshake        | payload
//   ---------+------------------+-------------------------------------
//   sample   | push / full      | in_item  (raw accel, raw gyro, time)
//   result   | pop / empty      | out_item (roll, pitch, yaw, elapsed)
//   config   | wr_en            | wr_index, wr_data
//
// The 24-step square root and the CORDIC run take up most of each sample's
// time in the engine, with the divide by 1000 running alongside them.
// A two-beat queue lets the next samples enter meanwhile.
// Reset (rst, synchronous) clears the angles, the last timestamp and
// the queues. A result waiting on pop holds the engine in its last step.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter_core #(
  parameter int CORDIC_ITERATIONS = imutf_pkg::CordicIterationsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  imutf_pkg::in_item_t  in_item,
  input  logic                 pop,
  output logic                 empty,
  output imutf_pkg::out_item_t out_item,
  input  logic                 wr_en,
  input  logic [2:0]           wr_index,
  input  logic [24:0]          wr_data
);
  import imutf_pkg::*;

  cfg_t  cfg;
  logic  q_full;
  logic  q_empty;
  logic  q_wr;
  logic  q_rd;
  work_t q_wdata;
  work_t q_rdata;

  imutf_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  imutf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_item (in_item),
    .full    (full),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_wdata (q_wdata)
  );

  imutf_fifo #(
    .DEPTH (QueueDepthDefault)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wdata   (q_wdata),
    .rd      (q_rd),
    .rdata   (q_rdata),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  imutf_back #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

// ===== hdl/imutf_fifo.sv =====
// ----------------------------------------------------------------------------
// imutf_fifo: short sample queue between front and back
// Flip-flop queue with registered entries and a fill count.
// ----------------------------------------------------------------------------
module imutf_fifo #(
  parameter int DEPTH = imutf_pkg::QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  imutf_pkg::work_t wdata,
  input  logic             rd,
  output imutf_pkg::work_t rdata,
  output logic             q_full,
  output logic             q_empty
);
  import imutf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  work_t           mem [DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [AW:0]     count;

  assign q_full  = (count == (AW+1)'(DEPTH));
  assign q_empty = (count == '0);
  assign rdata   = mem[rptr];

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  // store the incoming sample
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ===== hdl/imutf_front.sv =====
// ----------------------------------------------------------------------------
// imutf_front: sample intake
// Takes an input beat, works out the elapsed time from the previous
// timestamp and queues the sample for the back end.
// ----------------------------------------------------------------------------
module imutf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  imutf_pkg::in_item_t in_item,
  output logic                full,
  input  logic                q_full,
  output logic                q_wr,
  output imutf_pkg::work_t    q_wdata
);
  import imutf_pkg::*;

  logic [31:0] last_time;

  assign full = q_full;
  assign q_wr = push && !q_full;

  // classify: raw axes pass on, timestamp turns into elapsed time
  always_comb begin
    q_wdata.accel_x = in_item.accel_x;
    q_wdata.accel_y = in_item.accel_y;
    q_wdata.accel_z = in_item.accel_z;
    q_wdata.rate_x  = in_item.rate_x;
    q_wdata.rate_y  = in_item.rate_y;
    q_wdata.rate_z  = in_item.rate_z;
    q_wdata.dt      = in_item.timestamp_ms - last_time;
  end

  // hold the last accepted timestamp
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
    end else if (q_wr) begin
      last_time <= in_item.timestamp_ms;
    end
  end

endmodule

// ===== hdl/imutf_back.sv =====
// ----------------------------------------------------------------------------
// imutf_back: filter engine
// Square roots, CORDIC vectoring, gyro integration with a divide by 1000,
// complementary blend and the result register.
// ----------------------------------------------------------------------------
module imutf_back #(
  parameter int CORDIC_ITERATIONS = imutf_pkg::CordicIterationsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  imutf_pkg::cfg_t      cfg,
  input  logic                 q_empty,
  input  imutf_pkg::work_t     q_rdata,
  output logic                 q_rd,
  input  logic                 pop,
  output logic                 empty,
  output imutf_pkg::out_item_t out_item
);
  import imutf_pkg::*;

  localparam int Iters       = (CORDIC_ITERATIONS > AtanLen) ? AtanLen : CORDIC_ITERATIONS;
  localparam int SqrtSteps   = 24;
  localparam int CordicFirst = SqrtSteps + 1;
  localparam int DivCycles   = 8;
  localparam logic [5:0]  RunLast    = 6'(CordicFirst + Iters - 1);
  // ceil(2^36 / 1000): exact quotient for any value below 2^26
  localparam logic [26:0] Recip1000  = 27'd68719477;

  back_state_t state, state_next;
  logic        out_load;
  logic        out_valid;

  work_t              item;
  logic [5:0]         cnt;
  logic [30:0]        sq_x, sq_y, sq_z;
  logic signed [16:0] numer   [2];
  logic [47:0]        rad     [2];
  logic [47:0]        root    [2];
  logic [47:0]        bitv;
  logic signed [33:0] cx      [2];
  logic signed [33:0] cy      [2];
  logic signed [24:0] cz      [2];
  logic               zero    [2];
  logic signed [36:0] scaled  [3];
  logic signed [28:0] rate    [3];
  logic signed [45:0] plo     [3];
  logic signed [45:0] phi     [3];
  logic [63:0]        div_n   [3];
  logic [9:0]         div_r   [3];
  logic [15:0]        div_q   [3];
  logic               neg     [3];
  logic signed [31:0] gangle  [3];
  logic signed [25:0] acc     [2];
  logic signed [49:0] wg      [2];
  logic signed [43:0] wa      [2];

  // step logic
  logic [47:0]        trial   [2];
  logic signed [33:0] dx      [2];
  logic signed [33:0] dy      [2];
  logic [25:0]        dv_v    [3];
  logic [52:0]        dv_p    [3];
  logic signed [61:0] pfull   [3];
  logic [61:0]        pmag    [3];
  logic signed [15:0] raw     [3];
  logic signed [24:0] bias    [3];
  logic signed [23:0] aoff    [2];
  logic signed [62:0] asum    [3];
  logic signed [62:0] bsum    [2];
  logic [5:0]         step_idx;
  logic               cordic_on;
  logic [16:0]        wsat;
  logic [16:0]        wrem;

  function automatic logic signed [31:0] sat32(input logic signed [62:0] v);
    logic signed [31:0] r;
    if (v > 63'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -63'sh8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  assign empty = !out_valid;

  // sequence one sample through the engine
  always_comb begin
    state_next = state;
    q_rd       = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_rd       = 1'b1;
          state_next = BK_PREP_MUL;
        end
      end
      BK_PREP_MUL: state_next = BK_PREP_ADD;
      BK_PREP_ADD: state_next = BK_PREP_DT;
      BK_PREP_DT:  state_next = BK_PREP_DIV;
      BK_PREP_DIV: state_next = BK_RUN;
      BK_RUN: begin
        if (cnt == RunLast) begin
          state_next = BK_ANGLE;
        end
      end
      BK_ANGLE: state_next = BK_BLEND;
      BK_BLEND: state_next = BK_OUT;
      BK_OUT: begin
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // per-step arithmetic of root, CORDIC, divider and final sums
  always_comb begin
    raw[0]  = item.rate_x;
    raw[1]  = item.rate_y;
    raw[2]  = item.rate_z;
    bias[0] = cfg.offset_x;
    bias[1] = cfg.offset_y;
    bias[2] = cfg.offset_z;
    aoff[0] = cfg.offset_roll;
    aoff[1] = cfg.offset_pitch;
    step_idx  = cnt - 6'(CordicFirst);
    cordic_on = (cnt >= 6'(CordicFirst)) && (cnt < 6'(CordicFirst + Iters));
    wsat = (cfg.weight > 17'd65536) ? 17'd65536 : cfg.weight;
    wrem = 17'(18'd65536 - {1'b0, wsat});
    for (int l = 0; l < 2; l++) begin
      trial[l] = root[l] + bitv;
      dx[l]    = cx[l] >>> step_idx[4:0];
      dy[l]    = cy[l] >>> step_idx[4:0];
      bsum[l]  = (63'(wg[l]) + 63'(wa[l]) + 63'sd32768) >>> 16;
    end
    for (int k = 0; k < 3; k++) begin
      dv_v[k]  = {div_r[k], div_n[k][63:48]};
      dv_p[k]  = 53'(dv_v[k]) * 53'(Recip1000);
      pfull[k] = (62'(phi[k]) <<< 16) + 62'(plo[k]);
      pmag[k]  = pfull[k][61] ? 62'(-pfull[k]) : 62'(pfull[k]);
      asum[k]  = neg[k] ? 63'(gangle[k]) - $signed({1'b0, div_n[k][61:0]})
                        : 63'(gangle[k]) + $signed({1'b0, div_n[k][61:0]});
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_rd) begin
      item <= q_rdata;
    end
    unique case (state)
      BK_PREP_MUL: begin
        sq_x     <= item.accel_x * item.accel_x;
        sq_y     <= item.accel_y * item.accel_y;
        sq_z     <= item.accel_z * item.accel_z;
        numer[0] <= 17'(item.accel_y);
        numer[1] <= -17'(item.accel_x);
        for (int k = 0; k < 3; k++) begin
          scaled[k] <= raw[k] * $signed({1'b0, cfg.scale});
        end
      end
      BK_PREP_ADD: begin
        for (int k = 0; k < 3; k++) begin
          rate[k] <= 29'(((38'(scaled[k]) + 38'sd128) >>> 8) - 38'(bias[k]));
        end
      end
      BK_PREP_DT: begin
        for (int k = 0; k < 3; k++) begin
          plo[k] <= rate[k] * $signed({1'b0, item.dt[15:0]});
          phi[k] <= rate[k] * $signed({1'b0, item.dt[31:16]});
        end
      end
      BK_PREP_DIV: begin
        rad[0] <= {32'(sq_x) + 32'(sq_z), 16'd0};
        rad[1] <= {32'(sq_y) + 32'(sq_z), 16'd0};
        root[0] <= '0;
        root[1] <= '0;
        bitv    <= 48'h4000_0000_0000;
        for (int k = 0; k < 3; k++) begin
          div_n[k] <= {2'b00, pmag[k] + 62'd500};
          div_r[k] <= '0;
          neg[k]   <= pfull[k][61];
        end
      end
      BK_RUN: begin
        // divide by 1000, one 16-bit digit at a time by reciprocal: quotient digit, then remainder and shift
        if (cnt < 6'(DivCycles)) begin
          for (int k = 0; k < 3; k++) begin
            if (!cnt[0]) begin
              div_q[k] <= dv_p[k][51:36];
            end else begin
              div_r[k] <= 10'(dv_v[k] - 26'(div_q[k]) * 26'd1000);
              div_n[k] <= {div_n[k][47:0], div_q[k]};
            end
          end
        end
        if (cnt < 6'(SqrtSteps)) begin
          // digit-by-digit square root, one result bit a cycle
          bitv <= bitv >> 2;
          for (int l = 0; l < 2; l++) begin
            if (rad[l] >= trial[l]) begin
              rad[l]  <= rad[l] - trial[l];
              root[l] <= (root[l] >> 1) + bitv;
            end else begin
              root[l] <= root[l] >> 1;
            end
          end
        end else if (cnt == 6'(SqrtSteps)) begin
          for (int l = 0; l < 2; l++) begin
            cx[l]   <= $signed({4'd0, root[l][23:0], 6'd0});
            cy[l]   <= 34'($signed({numer[l], 14'd0}));
            cz[l]   <= '0;
            zero[l] <= (root[l][23:0] == '0) && (numer[l] == '0);
          end
        end else if (cordic_on) begin
          // rotate toward the x axis
          for (int l = 0; l < 2; l++) begin
            if (!cy[l][33]) begin
              cx[l] <= cx[l] + dy[l];
              cy[l] <= cy[l] - dx[l];
              cz[l] <= cz[l] + $signed({2'b00, atan_entry(step_idx[4:0])});
            end else begin
              cx[l] <= cx[l] - dy[l];
              cy[l] <= cy[l] + dx[l];
              cz[l] <= cz[l] - $signed({2'b00, atan_entry(step_idx[4:0])});
            end
          end
        end
      end
      BK_ANGLE: begin
        for (int l = 0; l < 2; l++) begin
          acc[l] <= (zero[l] ? 26'sd0 : 26'(cz[l])) - 26'(aoff[l]);
        end
      end
      BK_BLEND: begin
        for (int l = 0; l < 2; l++) begin
          wg[l] <= $signed({1'b0, wsat}) * gangle[l];
          wa[l] <= $signed({1'b0, wrem}) * acc[l];
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_item.roll       <= sat32(bsum[0]);
      out_item.pitch      <= sat32(bsum[1]);
      out_item.yaw        <= gangle[2];
      out_item.elapsed_ms <= item.dt;
    end
  end

  // run counter, integrated angles and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        gangle[k] <= '0;
      end
    end else begin
      if (state == BK_PREP_DIV) begin
        cnt <= '0;
      end else if (state == BK_RUN) begin
        cnt <= cnt + 1'b1;
      end
      if (state == BK_ANGLE) begin
        for (int k = 0; k < 3; k++) begin
          gangle[k] <= sat32(asum[k]);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  // queue is read only by an idle engine with a sample waiting
  a_rd_idle: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> (state == BK_IDLE) && !q_empty)
    else $error("sample taken while engine busy");

  // result register is never overwritten before its beat leaves
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || pop))
    else $error("result overwritten");

  // last CORDIC step hands over to the angle update
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RUN) && (cnt == RunLast) |=> (state == BK_ANGLE))
    else $error("run phase did not end");

  // a new result follows every finished run
  a_out_after_run: assert property (@(posedge clk) disable iff (rst)
    (state == BK_BLEND) |=> (state == BK_OUT))
    else $error("blend not followed by output");

endmodule

// ===== hdl/imutf_pkg_unused_guard.sv =====
// ----------------------------------------------------------------------------
// imutf_cfg: configuration register bank
// Holds offsets, gyro scale and blend weight written through the
// plain write port.
// ----------------------------------------------------------------------------
module imutf_cfg (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [2:0]      wr_index,
  input  logic [24:0]     wr_data,
  output imutf_pkg::cfg_t cfg
);
  import imutf_pkg::*;

  // write one register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_roll  <= '0;
      cfg.offset_pitch <= '0;
      cfg.offset_x     <= '0;
      cfg.offset_y     <= '0;
      cfg.offset_z     <= '0;
      cfg.scale        <= GyroScaleReset;
      cfg.weight       <= GyroWeightReset;
    end else if (wr_en) begin
      case (wr_index)
        REG_ACCEL_OFFSET_ROLL:  cfg.offset_roll  <= wr_data[23:0];
        REG_ACCEL_OFFSET_PITCH: cfg.offset_pitch <= wr_data[23:0];
        REG_GYRO_OFFSET_X:      cfg.offset_x     <= wr_data;
        REG_GYRO_OFFSET_Y:      cfg.offset_y     <= wr_data;
        REG_GYRO_OFFSET_Z:      cfg.offset_z     <= wr_data;
        REG_GYRO_SCALE:         cfg.scale        <= wr_data[19:0];
        REG_GYRO_WEIGHT:        cfg.weight       <= wr_data[16:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== bench/tb_imu_complementary_tilt_filter_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_imu_complementary_tilt_filter_core: self-checking bench of the tilt filter
// Drives IMU samples through the push/full side in random bursts, pops
// results under a stall pattern, and checks every beat against an in-bench
// model of the accel CORDIC, gyro integration and complementary blend.
// ----------------------------------------------------------------------------
module tb_imu_complementary_tilt_filter_core;
  import imutf_pkg::*;

  localparam int CordicSteps = 16;
  localparam int IdleLimit   = 20000;
  localparam int DrainCycles = 200;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      pop;
  logic      empty;
  out_item_t out_item;
  logic      wr_en;
  logic [2:0] wr_index;
  logic [24:0] wr_data;

  // Model copy of registers and angle state
  longint m_off_roll, m_off_pitch, m_off_x, m_off_y, m_off_z, m_scale, m_weight;
  longint m_ang_x, m_ang_y, m_yaw;
  logic [31:0] m_last_time;

  out_item_t pending_tilt[$];
  int        errors;
  int        idle_cycles;
  bit        stall_on;
  int        burst_left;

  imu_complementary_tilt_filter_core #(.CORDIC_ITERATIONS(CordicSteps)) u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .pop(pop), .empty(empty), .out_item(out_item),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint int_root(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint atan_step(int i);
    case (i)
      0: return 2949120;   1: return 1740967;   2: return 919879;
      3: return 466945;    4: return 234379;    5: return 117304;
      6: return 58666;     7: return 29335;     8: return 14668;
      9: return 7334;      10: return 3667;     11: return 1833;
      12: return 917;      13: return 458;      14: return 229;
      15: return 115;      16: return 57;       17: return 29;
      18: return 14;       19: return 7;        20: return 4;
      21: return 2;        22: return 1;
      default: return 0;
    endcase
  endfunction

  // Angle of (root(a^2+b^2), num) in 1/65536 degree
  function automatic longint tilt_angle(longint num, longint a, longint b);
    longint x, y, z, dx, dy;
    x = int_root(longint'(a * a + b * b) << 16) * 64;
    y = num * 256 * 64;
    z = 0;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x += dy; y -= dx; z += atan_step(i);
      end else begin
        x -= dy; y += dx; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint gyro_advance(longint ang, longint raw, longint bias,
                                          logic [31:0] dt);
    longint rate, p, q;
    rate = ((raw * m_scale + 128) >>> 8) - bias;
    p = rate * longint'({32'd0, dt});
    q = ((p < 0 ? -p : p) + 500) / 1000;
    return sat32(ang + (p < 0 ? -q : q));
  endfunction

  function automatic longint blend_angle(longint g, longint acc);
    longint w;
    w = m_weight > 65536 ? 65536 : m_weight;
    return sat32((w * g + (65536 - w) * acc + 32768) >>> 16);
  endfunction

  function automatic out_item_t predict_tilt(in_item_t s);
    out_item_t r;
    longint ax, ay, az, acc_r, acc_p;
    logic [31:0] dt;
    ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
    dt = s.timestamp_ms - m_last_time;
    acc_r = tilt_angle(ay, ax, az) - m_off_roll;
    acc_p = tilt_angle(-ax, ay, az) - m_off_pitch;
    m_last_time = s.timestamp_ms;
    m_ang_x = gyro_advance(m_ang_x, longint'(s.rate_x), m_off_x, dt);
    m_ang_y = gyro_advance(m_ang_y, longint'(s.rate_y), m_off_y, dt);
    m_yaw   = gyro_advance(m_yaw, longint'(s.rate_z), m_off_z, dt);
    r.roll = 32'(blend_angle(m_ang_x, acc_r));
    r.pitch = 32'(blend_angle(m_ang_y, acc_p));
    r.yaw = 32'(m_yaw);
    r.elapsed_ms = dt;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t",
             what, $signed(got), $signed(want), $realtime);
    errors++;
  endtask

  // Write one register while the block is idle
  task automatic write_reg(cfg_reg_t idx, logic [24:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_ACCEL_OFFSET_ROLL:  m_off_roll  = longint'($signed(val[23:0]));
      REG_ACCEL_OFFSET_PITCH: m_off_pitch = longint'($signed(val[23:0]));
      REG_GYRO_OFFSET_X:      m_off_x     = longint'($signed(val));
      REG_GYRO_OFFSET_Y:      m_off_y     = longint'($signed(val));
      REG_GYRO_OFFSET_Z:      m_off_z     = longint'($signed(val));
      REG_GYRO_SCALE:         m_scale     = longint'(val[19:0]);
      REG_GYRO_WEIGHT:        m_weight    = longint'(val[16:0]);
      default: ;
    endcase
  endtask

  // Send one sample, with a random gap before some bursts; push stays high in a burst
  task automatic send_sample(in_item_t s);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 90)) @(negedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    in_item <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_tilt.push_back(predict_tilt(s));
    @(negedge clk);
  endtask

  task automatic drain;
    push <= 1'b0;
    while (pending_tilt.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  function automatic in_item_t rand_sample(logic [31:0] t);
    in_item_t s;
    s = {$urandom, $urandom, $urandom, $urandom};
    s.timestamp_ms = t;
    return s;
  endfunction

  task automatic test_directed;
    in_item_t s;
    logic [15:0] edge_vals[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    // Zero over zero, first sample from time zero
    s = '0; s.timestamp_ms = 32'd10; send_sample(s);
    // Zero root with nonzero numerator
    s = '0; s.accel_y = 16'sh7fff; s.timestamp_ms = 32'd20; send_sample(s);
    s = '0; s.accel_x = 16'sh8000; s.timestamp_ms = 32'd30; send_sample(s);
    // Field extremes with long steps so angles saturate
    for (int i = 0; i < 10; i++) begin
      s.accel_x = edge_vals[i % 5];
      s.accel_y = edge_vals[(i + 1) % 5];
      s.accel_z = edge_vals[(i + 2) % 5];
      s.rate_x = (i < 5) ? 16'sh7fff : 16'sh8000;
      s.rate_y = (i < 5) ? 16'sh8000 : 16'sh7fff;
      s.rate_z = edge_vals[i % 5];
      s.timestamp_ms = 32'd30 + 32'(i) * 32'd400000000;
      send_sample(s);
    end
    // Timestamp wrap
    s = rand_sample(32'hffff_fff0); send_sample(s);
    s = rand_sample(32'h0000_0010); send_sample(s);
    s = rand_sample(32'h0000_0010); send_sample(s);
    drain();
  endtask

  task automatic test_register_extremes;
    logic [31:0] t;
    // Once the previous test has drained, set extremes including weight above one
    write_reg(REG_ACCEL_OFFSET_ROLL, 25'(-24'sd5898240));
    write_reg(REG_ACCEL_OFFSET_PITCH, 25'(24'sd5898240));
    write_reg(REG_GYRO_OFFSET_X, 25'h1000000);
    write_reg(REG_GYRO_OFFSET_Y, 25'h0ffffff);
    write_reg(REG_GYRO_OFFSET_Z, 25'h1ffffff);
    write_reg(REG_GYRO_SCALE, 25'hfffff);
    write_reg(REG_GYRO_WEIGHT, 25'h1ffff);
    t = m_last_time;
    for (int i = 0; i < 8; i++) begin
      t += $urandom_range(0, 5000);
      send_sample(rand_sample(t));
    end
    drain();
    write_reg(REG_GYRO_WEIGHT, 25'd0);
    write_reg(REG_GYRO_SCALE, 25'd0);
    for (int i = 0; i < 8; i++) begin
      t += $urandom_range(0, 5000);
      send_sample(rand_sample(t));
    end
    drain();
  endtask

  task automatic test_random_phases;
    logic [31:0] t;
    t = m_last_time;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_ACCEL_OFFSET_ROLL, 25'($signed($urandom_range(0, 11796480)) - 5898240));
      write_reg(REG_ACCEL_OFFSET_PITCH, 25'($signed($urandom_range(0, 11796480)) - 5898240));
      write_reg(REG_GYRO_OFFSET_X, 25'($urandom));
      write_reg(REG_GYRO_OFFSET_Y, 25'($signed($urandom_range(0, 4000)) - 2000));
      write_reg(REG_GYRO_OFFSET_Z, 25'($signed($urandom_range(0, 4000)) - 2000));
      write_reg(REG_GYRO_SCALE, (ph == 0) ? 25'(GyroScaleReset) : 25'($urandom_range(0, 1048575)));
      write_reg(REG_GYRO_WEIGHT, (ph == 0) ? 25'(GyroWeightReset) : 25'($urandom_range(0, 65536)));
      for (int i = 0; i < 190; i++) begin
        // Mostly short steps, sometimes long or wrapping jumps
        if ($urandom_range(0, 19) == 0) t += $urandom;
        else t += $urandom_range(0, 20);
        send_sample(rand_sample(t));
      end
      drain();
    end
  endtask

  // Result side: stall on its own pattern, check each popped beat
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_tilt.size() == 0) begin
        report_mismatch("unexpected result", out_item.roll, 32'd0);
      end else begin
        out_item_t want;
        want = pending_tilt.pop_front();
        if (out_item.roll != want.roll) report_mismatch("roll", out_item.roll, want.roll);
        if (out_item.pitch != want.pitch) report_mismatch("pitch", out_item.pitch, want.pitch);
        if (out_item.yaw != want.yaw) report_mismatch("yaw", out_item.yaw, want.yaw);
        if (out_item.elapsed_ms != want.elapsed_ms)
          report_mismatch("elapsed_ms", out_item.elapsed_ms, want.elapsed_ms);
      end
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_on = !stall_on;
    pop <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  // Watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || wr_en) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("imu_complementary_tilt_filter_core test failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1; push = 1'b0; pop = 1'b0; in_item = '0;
    wr_en = 1'b0; wr_index = '0; wr_data = '0;
    errors = 0; idle_cycles = 0; stall_on = 1'b0; burst_left = 0;
    m_off_roll = 0; m_off_pitch = 0; m_off_x = 0; m_off_y = 0; m_off_z = 0;
    m_scale = 128070; m_weight = 62915;
    m_ang_x = 0; m_ang_y = 0; m_yaw = 0; m_last_time = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_register_extremes();
    test_random_phases();
    drain();
    repeat (DrainCycles) @(negedge clk);
    if (errors == 0 && pending_tilt.size() == 0) begin
      $display("imu_complementary_tilt_filter_core test passed");
    end else begin
      $display("imu_complementary_tilt_filter_core test failed");
    end
    $finish;
  end
endmodule
